// File: rtl/sssp_pkg.sv
// Shared types and constants for the shortest-path core.
// No dependencies.
`default_nettype none
package sssp_pkg;
   localparam int MAX_NODES_DEF   = 1024;
   localparam int MAX_EDGES_DEF   = 4096;
   localparam int WEIGHT_BITS_DEF = 20;
   localparam int NODE_W          = 11;
   localparam int DIST_W          = 40;
   localparam int WGT_W           = 20;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_SOLVE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_INIT    = 10'b0000000010,
      ST_SCAN    = 10'b0000000100,
      ST_SCANW   = 10'b0000001000,
      ST_EDGE    = 10'b0000010000,
      ST_EREL    = 10'b0000100000,
      ST_RELW    = 10'b0001000000,
      ST_PATH    = 10'b0010000000,
      ST_PATHW   = 10'b0100000000,
      ST_DONE    = 10'b1000000000
   } state_type;
endpackage
`default_nettype wire

// File: rtl/single_source_shortest_path_core.sv
// Shortest-path core: edge store, node tables and the solve sequencer.
// Depends on sssp_pkg.
//
//  channel  ports               handshake
//  request  req_*, start        start & !busy
//  result   rsp_*, rsp_strobe   one-cycle strobe, no stall
//  config   csr_*               csr_valid & csr_ready
//
// Add and clear complete in the idle state; a read adds a stack-read state.
// The result strobes the cycle after the command finishes. Solve: init of
// N+1 entries, then per settled node a scan of N nodes and an edge pass over
// every stored edge, a final empty scan, then a path walk from the target to
// node 1; busy is high throughout. Reset is synchronous and clears control
// state only; the tables hold no valid bits. The receiver cannot stall.
`default_nettype none
module single_source_shortest_path_core #(
   parameter int MAX_EDGES   = sssp_pkg::MAX_EDGES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_func,
   input  wire logic [sssp_pkg::NODE_W-1:0] req_node_a,
   input  wire logic [sssp_pkg::NODE_W-1:0] req_node_b,
   input  wire logic [sssp_pkg::WGT_W-1:0]  req_weight,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [sssp_pkg::NODE_W-1:0] csr_node_count,
   output logic                             rsp_strobe,
   output logic                             rsp_edge_dropped,
   output logic                             rsp_reachable,
   output logic [sssp_pkg::DIST_W-1:0]      rsp_distance,
   output logic [sssp_pkg::NODE_W-1:0]      rsp_path_length,
   output logic [sssp_pkg::NODE_W-1:0]      rsp_path_node,
   output logic                             rsp_last
);
   localparam int MAX_NODES   = sssp_pkg::MAX_NODES_DEF;
   localparam int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF;
   localparam int NW = sssp_pkg::NODE_W;
   localparam int DW = sssp_pkg::DIST_W;
   localparam int AW = $clog2(MAX_NODES + 1);   // node table index
   localparam int EW = $clog2(MAX_EDGES);
   localparam int EC = $clog2(MAX_EDGES + 1);
   localparam int SW = $clog2(MAX_NODES);
   localparam int TW = DW + NW + 2;             // dist, pred, reached, settled

   // memories
   logic [2*NW+WEIGHT_BITS-1:0] edge_mem [MAX_EDGES];
   logic [TW-1:0]               node_mem [MAX_NODES+1];
   logic [NW-1:0]               stk_mem  [MAX_NODES];

   logic [2*NW+WEIGHT_BITS-1:0] edge_rd_ff;
   logic [TW-1:0]               node_rd_ff;
   logic [NW-1:0]               stk_rd_ff;

   sssp_pkg::state_type state_ff, state_in;
   logic [EC-1:0] etot_ff, etot_in;
   logic [NW-1:0] ncount_ff, ncount_in;
   logic [NW-1:0] cursor_ff, cursor_in;
   logic [NW-1:0] lim_ff, lim_in;
   logic [AW-1:0] vi_ff, vi_in;        // scan/init/path index
   logic [NW-1:0] cur_ff, cur_in;      // node being settled
   logic [DW-1:0] curd_ff, curd_in;
   logic          found_ff, found_in;
   logic [NW-1:0] bestn_ff, bestn_in;
   logic [DW-1:0] bestd_ff, bestd_in;
   logic [EC-1:0] ei_ff, ei_in;
   logic          side_ff, side_in;    // which endpoint of the edge
   logic [NW-1:0] len_ff, len_in;
   logic          rsp_v_ff, rsp_v_in;
   logic          rdrop_ff, rdrop_in, rreach_ff, rreach_in, rlast_ff, rlast_in;
   logic [DW-1:0] rdist_ff, rdist_in;
   logic [NW-1:0] rlen_ff, rlen_in, rnode_ff, rnode_in;

   // memory request lines
   logic          nwe;
   logic [AW-1:0] nwa, nra;
   logic [TW-1:0] nwd;
   logic          ewe;
   logic [EW-1:0] ewa, era;
   logic          swe;
   logic [SW-1:0] swa, sra;
   logic [NW-1:0] swd;

   always_ff @(posedge clock) begin
      if (ewe) edge_mem[ewa] <= {req_node_a, req_node_b, req_weight[WEIGHT_BITS-1:0]};
      edge_rd_ff <= edge_mem[era];
   end
   always_ff @(posedge clock) begin
      if (nwe) node_mem[nwa] <= nwd;
      node_rd_ff <= node_mem[nra];
   end
   always_ff @(posedge clock) begin
      if (swe) stk_mem[swa] <= swd;
      stk_rd_ff <= stk_mem[sra];
   end

   wire accept = start && !busy;
   assign busy      = !(state_ff == sssp_pkg::ST_IDLE);
   assign csr_ready = !busy;

   // node table fields
   wire [DW-1:0] rd_dist  = node_rd_ff[TW-1 -: DW];
   wire [NW-1:0] rd_pred  = node_rd_ff[NW+1 : 2];
   wire          rd_reach = node_rd_ff[1];
   wire          rd_sett  = node_rd_ff[0];

   wire [NW-1:0] e_a = edge_rd_ff[2*NW+WEIGHT_BITS-1 -: NW];
   wire [NW-1:0] e_b = edge_rd_ff[NW+WEIGHT_BITS-1 -: NW];
   wire [DW-1:0] e_w = DW'(edge_rd_ff[WEIGHT_BITS-1:0]);

   wire [NW-1:0] vi_n = NW'(vi_ff);

   always_comb begin
      state_in = state_ff; etot_in = etot_ff; ncount_in = ncount_ff;
      cursor_in = cursor_ff; lim_in = lim_ff; vi_in = vi_ff; cur_in = cur_ff;
      curd_in = curd_ff; found_in = found_ff; bestn_in = bestn_ff;
      bestd_in = bestd_ff; ei_in = ei_ff; side_in = side_ff; len_in = len_ff;
      rsp_v_in = 1'b0; rdrop_in = 1'b0; rreach_in = 1'b0; rlast_in = 1'b0;
      rdist_in = '0; rlen_in = '0; rnode_in = '0;
      nwe = 1'b0; nwa = '0; nwd = '0; nra = '0;
      ewe = 1'b0; ewa = EW'(etot_ff); era = EW'(ei_ff);
      swe = 1'b0; swa = SW'(len_ff); swd = '0; sra = SW'(cursor_ff - 1'b1);

      if (csr_valid && csr_ready) ncount_in = csr_node_count;

      case (state_ff)
         sssp_pkg::ST_IDLE: begin
            if (accept) begin
               case (sssp_pkg::func_type'(req_func))
                  sssp_pkg::FUNC_ADD: begin
                     rsp_v_in = 1'b1;
                     if (etot_ff >= EC'(MAX_EDGES)) rdrop_in = 1'b1;
                     else begin
                        ewe = 1'b1;
                        etot_in = etot_ff + 1'b1;
                     end
                  end
                  sssp_pkg::FUNC_SOLVE: begin
                     if (ncount_ff == '0) lim_in = NW'(1);
                     else if (32'(ncount_ff) > MAX_NODES) lim_in = NW'(MAX_NODES);
                     else lim_in = ncount_ff;
                     vi_in = '0;
                     state_in = sssp_pkg::ST_INIT;
                  end
                  sssp_pkg::FUNC_READ: begin
                     state_in = sssp_pkg::ST_DONE;   // wait for stack read
                  end
                  default: begin
                     etot_in = '0;
                     rsp_v_in = 1'b1;
                  end
               endcase
            end
         end
         sssp_pkg::ST_INIT: begin
            nwe = 1'b1; nwa = vi_ff;
            nwd = (vi_ff == AW'(1)) ? {{DW{1'b0}}, {NW{1'b0}}, 2'b10} : '0;
            if (vi_n == lim_ff) begin
               vi_in = AW'(1); found_in = 1'b0;
               state_in = sssp_pkg::ST_SCAN;
            end else vi_in = vi_ff + 1'b1;
         end
         sssp_pkg::ST_SCAN: begin
            nra = vi_ff;
            state_in = sssp_pkg::ST_SCANW;
         end
         sssp_pkg::ST_SCANW: begin
            // ascending scan: <= lets the larger node win ties
            if (rd_reach && !rd_sett && (!found_ff || rd_dist <= bestd_ff)) begin
               found_in = 1'b1; bestn_in = vi_n; bestd_in = rd_dist;
            end
            if (vi_n == lim_ff) begin
               if (!found_in) begin
                  vi_in = AW'(lim_ff); state_in = sssp_pkg::ST_PATH;
                  len_in = '0;
               end else begin
                  cur_in = bestn_in; curd_in = bestd_in;
                  ei_in = '0; side_in = 1'b0;
                  state_in = sssp_pkg::ST_EDGE;
                  // mark settled
                  nra = AW'(bestn_in);
               end
            end else begin
               vi_in = vi_ff + 1'b1;
               state_in = sssp_pkg::ST_SCAN;
            end
         end
         sssp_pkg::ST_EDGE: begin
            // first cycle after pick: node_rd holds cur's entry
            if (rd_dist == curd_ff && !rd_sett && ei_ff == '0 && !side_ff) begin
               nwe = 1'b1; nwa = AW'(cur_ff); nwd = {node_rd_ff[TW-1:1], 1'b1};
            end
            if (ei_ff >= etot_ff || ei_ff >= EC'(MAX_EDGES)) begin
               vi_in = AW'(1); found_in = 1'b0;
               state_in = sssp_pkg::ST_SCAN;
            end else begin
               era = EW'(ei_ff);
               state_in = sssp_pkg::ST_EREL;
            end
         end
         sssp_pkg::ST_EREL: begin
            // edge word ready; read the far endpoint's entry
            if (!side_ff) nra = (e_a == cur_ff) ? AW'(e_b) : '0;
            else          nra = (e_b == cur_ff) ? AW'(e_a) : '0;
            era = EW'(ei_ff);
            state_in = sssp_pkg::ST_RELW;
         end
         sssp_pkg::ST_RELW: begin
            logic [NW-1:0] to;
            logic          hit;
            logic [DW-1:0] cand;
            to   = side_ff ? e_a : e_b;
            hit  = side_ff ? (e_b == cur_ff) : (e_a == cur_ff);
            cand = curd_ff + e_w;
            if (hit && to >= NW'(1) && to <= lim_ff &&
                (!rd_reach || cand < rd_dist)) begin
               nwe = 1'b1; nwa = AW'(to);
               nwd = {cand, cur_ff, 1'b1, rd_sett};
            end
            if (!side_ff) begin
               side_in = 1'b1;
               state_in = sssp_pkg::ST_EREL;
            end else begin
               side_in = 1'b0; ei_in = ei_ff + 1'b1;
               state_in = sssp_pkg::ST_EDGE;
            end
         end
         sssp_pkg::ST_PATH: begin
            nra = vi_ff;
            rdist_in = rdist_ff;   // hold the target distance over the walk
            state_in = sssp_pkg::ST_PATHW;
         end
         sssp_pkg::ST_PATHW: begin
            if (len_ff == '0 && !rd_reach) begin
               cursor_in = '0; rsp_v_in = 1'b1;
               state_in = sssp_pkg::ST_IDLE;
            end else begin
               if (len_ff == '0) rdist_in = rd_dist;
               else rdist_in = rdist_ff;
               if (vi_n != NW'(1) && vi_n >= NW'(1) && vi_n <= lim_ff &&
                   32'(len_ff) < MAX_NODES - 1) begin
                  swe = 1'b1; swd = vi_n;
                  len_in = len_ff + 1'b1;
                  vi_in = AW'(rd_pred);
                  state_in = sssp_pkg::ST_PATH;
               end else begin
                  swe = 1'b1; swd = NW'(1);
                  len_in = len_ff + 1'b1;
                  cursor_in = len_in;
                  rsp_v_in = 1'b1; rreach_in = 1'b1; rlen_in = len_in;
                  state_in = sssp_pkg::ST_IDLE;
               end
            end
            if (state_in == sssp_pkg::ST_IDLE && !rreach_in) rdist_in = '0;
         end
         sssp_pkg::ST_DONE: begin
            rsp_v_in = 1'b1;
            if (cursor_ff != '0 && 32'(cursor_ff) <= MAX_NODES) begin
               cursor_in = cursor_ff - 1'b1;
               rnode_in = stk_rd_ff;
               rlast_in = (cursor_in == '0);
            end else begin
               cursor_in = '0; rlast_in = 1'b1;
            end
            state_in = sssp_pkg::ST_IDLE;
         end
         default: state_in = sssp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sssp_pkg::ST_IDLE;
         etot_ff <= '0; ncount_ff <= NW'(1); cursor_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         etot_ff <= etot_in; ncount_ff <= ncount_in; cursor_ff <= cursor_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff <= lim_in; vi_ff <= vi_in; cur_ff <= cur_in; curd_ff <= curd_in;
      found_ff <= found_in; bestn_ff <= bestn_in; bestd_ff <= bestd_in;
      ei_ff <= ei_in; side_ff <= side_in; len_ff <= len_in;
      rdrop_ff <= rdrop_in; rreach_ff <= rreach_in; rlast_ff <= rlast_in;
      rdist_ff <= rdist_in; rlen_ff <= rlen_in; rnode_ff <= rnode_in;
   end

   assign rsp_strobe       = rsp_v_ff;
   assign rsp_edge_dropped = rdrop_ff;
   assign rsp_reachable    = rreach_ff;
   assign rsp_distance     = rreach_ff ? rdist_ff : '0;
   assign rsp_path_length  = rlen_ff;
   assign rsp_path_node    = rnode_ff;
   assign rsp_last         = rlast_ff;
endmodule
`default_nettype wire
